[hdl/vpa_pkg.sv]
// Shared types, constants and helper functions for the 2D vector polar ALU.
`default_nettype none
package vpa_pkg;

    localparam int unsigned DATA_WIDTH        = 32;
    localparam int unsigned FRAC_BITS         = 16;
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned ANGLE_TAB_LEN     = 30;
    localparam int unsigned CW                = DATA_WIDTH + 3;
    localparam int unsigned WIDE              = 2 * DATA_WIDTH + 8;

    typedef enum logic [2:0] {
        MODE_POL2RECT = 3'd0,
        MODE_RECT2POL = 3'd1,
        MODE_ADD      = 3'd2,
        MODE_SUB      = 3'd3,
        MODE_DOT      = 3'd4,
        MODE_CROSS    = 3'd5,
        MODE_SCALE    = 3'd6,
        MODE_NEGATE   = 3'd7
    } mode_t;

    typedef struct packed {
        logic                         ovf;
        logic signed [DATA_WIDTH-1:0] val;
    } sat_t;

    typedef struct packed {
        mode_t                        mode;
        logic                         zero;
        logic                         negrho;
        logic                         ovf;
        logic signed [DATA_WIDTH-1:0] rx;
        logic signed [DATA_WIDTH-1:0] ry;
        logic signed [CW-1:0]         x;
        logic signed [CW-1:0]         y;
        logic signed [CW-1:0]         z;
    } cell_t;

    localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
    localparam int unsigned PI_SH     = 61 - FRAC_BITS;
    localparam logic [63:0] PI_U      = (PI_Q61 + (64'd1 << (PI_SH - 1))) >> PI_SH;
    localparam logic [63:0] TWO_PI_U  = PI_U << 1;
    localparam logic [63:0] HALF_PI_U = PI_U >> 1;

    localparam logic signed [CW-1:0] PI_C      = CW'(PI_U);
    localparam logic signed [CW-1:0] TWO_PI_C  = CW'(TWO_PI_U);
    localparam logic signed [CW-1:0] HALF_PI_C = CW'(HALF_PI_U);

    localparam int unsigned RECIP_SHIFT = 32 + FRAC_BITS;
    localparam int unsigned RW          = 32;
    localparam logic [63:0] RECIP_U     = (64'd1 << RECIP_SHIFT) / TWO_PI_U;
    localparam logic signed [RW-1:0] RECIP_C = RW'(RECIP_U);
    localparam int unsigned QW          = CW + RW - RECIP_SHIFT;

    localparam int unsigned GAIN_SH = 30;
    localparam logic signed [30:0] INV_GAIN_C = 31'h26DD3B6A;

    localparam logic signed [WIDE-1:0] FRAC_HALF = WIDE'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [WIDE-1:0] GAIN_HALF = WIDE'(1) <<< (GAIN_SH - 1);

    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE-1:0] SAT_MAX = WIDE'(OUT_MAX);
    localparam logic signed [WIDE-1:0] SAT_MIN = WIDE'(OUT_MIN);

    localparam int unsigned ANGLE_SH  = 30 - FRAC_BITS;
    localparam logic [32:0] ATAN_RND  = (ANGLE_SH == 0) ? 33'd0 : (33'd1 << (ANGLE_SH - 1));

    localparam logic [31:0] ATAN_Q30 [ANGLE_TAB_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    function automatic logic signed [CW-1:0] atan_q(input int unsigned i);
        logic [32:0] tr;
        tr = {1'b0, ATAN_Q30[i % ANGLE_TAB_LEN]} + ATAN_RND;
        return CW'(tr >> ANGLE_SH);
    endfunction

    function automatic sat_t sat_dw(input logic signed [WIDE-1:0] v);
        sat_t s;
        if (v > SAT_MAX) begin
            s.ovf = 1'b1;
            s.val = OUT_MAX;
        end else if (v < SAT_MIN) begin
            s.ovf = 1'b1;
            s.val = OUT_MIN;
        end else begin
            s.ovf = 1'b0;
            s.val = v[DATA_WIDTH-1:0];
        end
        return s;
    endfunction

    function automatic logic signed [WIDE-1:0] round_frac(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] t;
        t = v + FRAC_HALF;
        return t >>> FRAC_BITS;
    endfunction

endpackage
`default_nettype wire

[hdl/vpa_operand_if.sv]
// Operand channel: valid/ready handshake carrying mode and two vectors.
`default_nettype none
interface vpa_operand_if;
    import vpa_pkg::*;
    logic                         valid;
    logic                         ready;
    mode_t                        mode;
    logic signed [DATA_WIDTH-1:0] ax;
    logic signed [DATA_WIDTH-1:0] ay;
    logic signed [DATA_WIDTH-1:0] bx;
    logic signed [DATA_WIDTH-1:0] by;

    modport source (output valid, mode, ax, ay, bx, by, input ready);
    modport sink   (input valid, mode, ax, ay, bx, by, output ready);
endinterface
`default_nettype wire

[hdl/vpa_result_if.sv]
// Result channel: valid/ready handshake carrying the result vector and flags.
`default_nettype none
interface vpa_result_if;
    import vpa_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_x;
    logic signed [DATA_WIDTH-1:0] res_y;
    logic                         negative_rho;
    logic                         overflow;

    modport source (output valid, res_x, res_y, negative_rho, overflow, input ready);
    modport sink   (input valid, res_x, res_y, negative_rho, overflow, output ready);
endinterface
`default_nettype wire

[hdl/vpa_pre.sv]
// Front pipeline: angle reduction, products, simple ops and CORDIC seeding.
`default_nettype none
module vpa_pre (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  valid_in,
    input  vpa_pkg::mode_t                        mode,
    input  logic signed [vpa_pkg::DATA_WIDTH-1:0] ax,
    input  logic signed [vpa_pkg::DATA_WIDTH-1:0] ay,
    input  logic signed [vpa_pkg::DATA_WIDTH-1:0] bx,
    input  logic signed [vpa_pkg::DATA_WIDTH-1:0] by,
    output logic                                  valid_out,
    output vpa_pkg::cell_t                        cell_out
);
    import vpa_pkg::*;

    localparam int unsigned X0W = DATA_WIDTH + 31;
    localparam logic signed [X0W-1:0] X0_HALF = X0W'(1) <<< (GAIN_SH - 1);

    logic v1_reg, v2_reg, v3_reg;

    mode_t                        mode1_reg, mode1_next;
    logic signed [CW-1:0]         u1_reg, u1_next;
    logic signed [CW+RW-1:0]      qp1_reg, qp1_next;
    logic signed [X0W-1:0]        x0p1_reg, x0p1_next;
    logic signed [2*DATA_WIDTH-1:0] m1_reg, m1_next, m2_reg, m2_next;
    sat_t                         sx1_reg, sx1_next, sy1_reg, sy1_next;
    logic signed [CW-1:0]         rx1_reg, rx1_next, ry1_reg, ry1_next, rz1_reg, rz1_next;
    logic                         zero1_reg, zero1_next, neg1_reg, neg1_next;

    mode_t                        mode2_reg;
    logic signed [CW-1:0]         r2_reg, r2_next, x02_reg, x02_next;
    logic signed [WIDE-1:0]       s1_2_reg, s1_2_next, s2_2_reg, s2_2_next;
    sat_t                         sx2_reg, sy2_reg;
    logic signed [CW-1:0]         rx2_reg, ry2_reg, rz2_reg;
    logic                         zero2_reg, neg2_reg;

    cell_t                        cell_reg, cell_next;

    logic signed [DATA_WIDTH-1:0] opb1, opb2;
    logic signed [QW-1:0]         q2;
    logic signed [QW+CW-1:0]      qt2;
    logic signed [X0W-1:0]        x0sum;
    logic signed [CW-1:0]         rr3, zc3, zf3;
    logic                         flip3;
    sat_t                         p1s, p2s;

    always_comb
    begin
        mode1_next = mode;
        u1_next    = CW'(ay) + PI_C;
        qp1_next   = (CW+RW)'(u1_next) * (CW+RW)'(RECIP_C);
        x0p1_next  = X0W'(ax) * X0W'(INV_GAIN_C);
        opb1       = (mode == MODE_CROSS) ? by : bx;
        opb2       = (mode == MODE_DOT) ? by : bx;
        m1_next    = (2*DATA_WIDTH)'(ax) * (2*DATA_WIDTH)'(opb1);
        m2_next    = (2*DATA_WIDTH)'(ay) * (2*DATA_WIDTH)'(opb2);
        sx1_next   = '0;
        sy1_next   = '0;
        unique case (mode)
            MODE_ADD:
            begin
                sx1_next = sat_dw(WIDE'(ax) + WIDE'(bx));
                sy1_next = sat_dw(WIDE'(ay) + WIDE'(by));
            end
            MODE_SUB:
            begin
                sx1_next = sat_dw(WIDE'(ax) - WIDE'(bx));
                sy1_next = sat_dw(WIDE'(ay) - WIDE'(by));
            end
            MODE_NEGATE:
            begin
                sx1_next = sat_dw(-WIDE'(ax));
                sy1_next = sat_dw(-WIDE'(ay));
            end
            MODE_POL2RECT, MODE_RECT2POL, MODE_DOT, MODE_CROSS, MODE_SCALE:
            begin
                sx1_next = '0;
                sy1_next = '0;
            end
        endcase
        if (ax[DATA_WIDTH-1])
        begin
            rx1_next = -CW'(ax);
            ry1_next = -CW'(ay);
            rz1_next = ay[DATA_WIDTH-1] ? -PI_C : PI_C;
        end else begin
            rx1_next = CW'(ax);
            ry1_next = CW'(ay);
            rz1_next = '0;
        end
        zero1_next = (ax == '0) && (ay == '0);
        neg1_next  = (mode == MODE_POL2RECT) && ax[DATA_WIDTH-1];
    end

    always_comb
    begin
        q2       = qp1_reg[CW+RW-1:RECIP_SHIFT];
        qt2      = (QW+CW)'(q2) * (QW+CW)'(TWO_PI_C);
        r2_next  = u1_reg - qt2[CW-1:0];
        x0sum    = x0p1_reg + X0_HALF;
        x02_next = CW'($signed(x0sum[X0W-1:GAIN_SH]));
        s2_2_next = WIDE'(m2_reg);
        unique case (mode1_reg)
            MODE_DOT:   s1_2_next = WIDE'(m1_reg) + WIDE'(m2_reg);
            MODE_CROSS: s1_2_next = WIDE'(m1_reg) - WIDE'(m2_reg);
            MODE_POL2RECT, MODE_RECT2POL, MODE_ADD, MODE_SUB, MODE_SCALE, MODE_NEGATE:
                s1_2_next = WIDE'(m1_reg);
        endcase
    end

    always_comb
    begin
        if (r2_reg < 0)
            rr3 = r2_reg + TWO_PI_C;
        else if (r2_reg >= TWO_PI_C)
            rr3 = r2_reg - TWO_PI_C;
        else
            rr3 = r2_reg;
        zc3   = rr3 - PI_C;
        flip3 = 1'b0;
        zf3   = zc3;
        if (zc3 > HALF_PI_C)
        begin
            zf3   = zc3 - PI_C;
            flip3 = 1'b1;
        end else if (zc3 < -HALF_PI_C)
        begin
            zf3   = zc3 + PI_C;
            flip3 = 1'b1;
        end
        p1s = sat_dw(round_frac(s1_2_reg));
        p2s = sat_dw(round_frac(s2_2_reg));

        cell_next        = '0;
        cell_next.mode   = mode2_reg;
        cell_next.zero   = zero2_reg;
        cell_next.negrho = neg2_reg;
        unique case (mode2_reg)
            MODE_POL2RECT:
            begin
                cell_next.x = flip3 ? -x02_reg : x02_reg;
                cell_next.y = '0;
                cell_next.z = zf3;
            end
            MODE_RECT2POL:
            begin
                cell_next.x = rx2_reg;
                cell_next.y = ry2_reg;
                cell_next.z = rz2_reg;
            end
            MODE_DOT, MODE_CROSS:
            begin
                cell_next.rx  = p1s.val;
                cell_next.ovf = p1s.ovf;
            end
            MODE_SCALE:
            begin
                cell_next.rx  = p1s.val;
                cell_next.ry  = p2s.val;
                cell_next.ovf = p1s.ovf | p2s.ovf;
            end
            MODE_ADD, MODE_SUB, MODE_NEGATE:
            begin
                cell_next.rx  = sx2_reg.val;
                cell_next.ry  = sy2_reg.val;
                cell_next.ovf = sx2_reg.ovf | sy2_reg.ovf;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= mode1_next;
            u1_reg    <= u1_next;
            qp1_reg   <= qp1_next;
            x0p1_reg  <= x0p1_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            sx1_reg   <= sx1_next;
            sy1_reg   <= sy1_next;
            rx1_reg   <= rx1_next;
            ry1_reg   <= ry1_next;
            rz1_reg   <= rz1_next;
            zero1_reg <= zero1_next;
            neg1_reg  <= neg1_next;

            mode2_reg <= mode1_reg;
            r2_reg    <= r2_next;
            x02_reg   <= x02_next;
            s1_2_reg  <= s1_2_next;
            s2_2_reg  <= s2_2_next;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            rx2_reg   <= rx1_reg;
            ry2_reg   <= ry1_reg;
            rz2_reg   <= rz1_reg;
            zero2_reg <= zero1_reg;
            neg2_reg  <= neg1_reg;

            cell_reg  <= cell_next;
        end
    end

    assign valid_out = v3_reg;
    assign cell_out  = cell_reg;

endmodule
`default_nettype wire

[hdl/vpa_cell.sv]
// One CORDIC micro-rotation cell of the rotation/vectoring chain.
`default_nettype none
module vpa_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           valid_in,
    input  vpa_pkg::cell_t cell_in,
    output logic           valid_out,
    output vpa_pkg::cell_t cell_out
);
    import vpa_pkg::*;

    localparam logic signed [CW-1:0] ANGLE = atan_q(SHIFT);

    logic                 valid_reg;
    cell_t                cell_reg, cell_next;
    logic signed [CW-1:0] xs, ys;
    logic                 sigma;

    always_comb
    begin
        xs    = cell_in.x >>> SHIFT;
        ys    = cell_in.y >>> SHIFT;
        sigma = (cell_in.mode == MODE_POL2RECT) ? ~cell_in.z[CW-1] : cell_in.y[CW-1];
        cell_next = cell_in;
        if (sigma)
        begin
            cell_next.x = cell_in.x - ys;
            cell_next.y = cell_in.y + xs;
            cell_next.z = cell_in.z - ANGLE;
        end else begin
            cell_next.x = cell_in.x + ys;
            cell_next.y = cell_in.y - xs;
            cell_next.z = cell_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cell_reg <= cell_next;
    end

    assign valid_out = valid_reg;
    assign cell_out  = cell_reg;

endmodule
`default_nettype wire

[hdl/vpa_post.sv]
// Back pipeline: gain correction, saturation, result selection and output register.
`default_nettype none
module vpa_post (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  vpa_pkg::cell_t      cell_in,
    output logic                adv,
    vpa_result_if.source        result
);
    import vpa_pkg::*;

    localparam int unsigned PW = CW + 31;

    logic                         v1_reg, out_valid_reg;
    cell_t                        c1_reg;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [DATA_WIDTH-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic                         neg_reg, neg_next, ovf_reg, ovf_next;
    sat_t                         sx, sy, sr, sz;
    logic signed [WIDE-1:0]       rp;

    assign adv = !out_valid_reg || result.ready;

    always_comb
    begin
        prod_next = PW'(cell_in.x) * PW'(INV_GAIN_C);
    end

    always_comb
    begin
        rp = (WIDE'(prod_reg) + GAIN_HALF) >>> GAIN_SH;
        sx = sat_dw(WIDE'(c1_reg.x));
        sy = sat_dw(WIDE'(c1_reg.y));
        sr = sat_dw(rp);
        sz = sat_dw(WIDE'(c1_reg.z));
        rx_next  = c1_reg.rx;
        ry_next  = c1_reg.ry;
        ovf_next = c1_reg.ovf;
        neg_next = 1'b0;
        unique case (c1_reg.mode)
            MODE_POL2RECT:
            begin
                if (c1_reg.negrho)
                begin
                    rx_next  = '0;
                    ry_next  = '0;
                    ovf_next = 1'b0;
                    neg_next = 1'b1;
                end else begin
                    rx_next  = sx.val;
                    ry_next  = sy.val;
                    ovf_next = sx.ovf | sy.ovf;
                end
            end
            MODE_RECT2POL:
            begin
                if (c1_reg.zero)
                begin
                    rx_next  = '0;
                    ry_next  = '0;
                    ovf_next = 1'b0;
                end else begin
                    rx_next  = sr.val;
                    ry_next  = sz.val;
                    ovf_next = sr.ovf | sz.ovf;
                end
            end
            MODE_ADD, MODE_SUB, MODE_DOT, MODE_CROSS, MODE_SCALE, MODE_NEGATE:
            begin
                rx_next  = c1_reg.rx;
                ry_next  = c1_reg.ry;
                ovf_next = c1_reg.ovf;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv)
        begin
            v1_reg        <= valid_in;
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= cell_in;
            prod_reg <= prod_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.res_x        = rx_reg;
    assign result.res_y        = ry_reg;
    assign result.negative_rho = neg_reg;
    assign result.overflow     = ovf_reg;

endmodule
`default_nettype wire

[hdl/vector2d_polar_alu_unit.sv]
// Top level: 2D vector ALU with a pipelined CORDIC chain for polar conversion.
// Every mode passes through the same pipeline from operand transfer to result valid.
// Throughput: one operand transfer per cycle; the whole pipeline holds only while
// the output register is full and not taken.
// Reset clears every stage valid bit and the output valid; data registers are not reset.
`default_nettype none
module vector2d_polar_alu_unit #(
    parameter int unsigned CORDIC_STAGES = vpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vpa_operand_if.sink   operands,
    vpa_result_if.source  result
);
    import vpa_pkg::*;

    localparam int unsigned NSTG =
        (CORDIC_STAGES < ANGLE_TAB_LEN) ? CORDIC_STAGES : ANGLE_TAB_LEN;

    logic  adv;
    logic  chain_valid [NSTG+1];
    cell_t chain_cell  [NSTG+1];

    assign operands.ready = adv;

    vpa_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (operands.valid),
        .mode      (operands.mode),
        .ax        (operands.ax),
        .ay        (operands.ay),
        .bx        (operands.bx),
        .by        (operands.by),
        .valid_out (chain_valid[0]),
        .cell_out  (chain_cell[0])
    );

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cell
        vpa_cell #(.SHIFT(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (chain_valid[g]),
            .cell_in   (chain_cell[g]),
            .valid_out (chain_valid[g+1]),
            .cell_out  (chain_cell[g+1])
        );
    end

    vpa_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (chain_valid[NSTG]),
        .cell_in  (chain_cell[NSTG]),
        .adv      (adv),
        .result   (result)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !operands.ready |-> (result.valid && !result.ready))
        else $error("operand side stalled without a held result");

    a_negrho_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.negative_rho) |->
            (result.res_x == '0 && result.res_y == '0 && !result.overflow))
        else $error("negative rho result not cleared");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overflow) |->
            (result.res_x == OUT_MAX || result.res_x == OUT_MIN ||
             result.res_y == OUT_MAX || result.res_y == OUT_MIN))
        else $error("overflow flagged without a saturated field");

endmodule
`default_nettype wire
